// ===== rtl/plq_pkg.sv =====
package plq_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  localparam logic [1:0] RD_HERE = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_SKIP = 2'd2;

  typedef struct packed {
    logic       load;
    logic       add_wr;
    logic       step;
    logic       shift_wr;
    logic       vol_wr;
    logic       erase_sum;
    logic       dec;
    logic       set_status;
    logic [1:0] status;
    logic [1:0] rd_off;
    logic       out_load;
  } plq_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       empty;
    logic       match;
    logic       last;
    logic       anon;
    logic       vol_eq;
    logic       vol_gt;
  } plq_stat_t;

endpackage

// ===== rtl/price_level_order_queue.sv =====
// Channel | Direction | Handshake             | Word
// in      | input     | in_valid_i/in_stall_o | cmd, order_id, order_volume
// out     | output    | out_valid_o/out_stall_i | status, order_count, total_volume
//
// Add and query pass through accept, execute and done; a remove also searches
// the stored orders in turn for the order id and, when the order is erased,
// shifts the later orders down to close the gap, one memory read per cycle.
// Reset clears the order count and running total; stores need no clearing.
// Input is stalled while a word is in work; a held result does not block
// the next accept, only the delivery of the following result.
module price_level_order_queue #(
  parameter int MAX_ORDERS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_cmd_i,
  input  logic [31:0] in_order_id_i,
  input  logic [31:0] in_order_volume_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_status_o,
  output logic [6:0]  out_order_count_o,
  output logic [31:0] out_total_volume_o
);
  import plq_pkg::*;

  plq_cmd_t  cmd;
  plq_stat_t stat;

  plq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  plq_dp #(
    .MAX_ORDERS (MAX_ORDERS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_cmd_i           (in_cmd_i),
    .in_order_id_i      (in_order_id_i),
    .in_order_volume_i  (in_order_volume_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_status_o       (out_status_o),
    .out_order_count_o  (out_order_count_o),
    .out_total_volume_o (out_total_volume_o)
  );

endmodule

// ===== rtl/plq_ctrl.sv =====
module plq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  plq_pkg::plq_stat_t stat_i,
  output plq_pkg::plq_cmd_t  cmd_o
);
  import plq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_off = RD_HERE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.cmd)
          CMD_ADD: begin
            cmd_o.set_status = 1'b1;
            if (stat_i.full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.add_wr = 1'b1;
              cmd_o.status = ST_OK;
            end
            state_d = S_DONE;
          end
          CMD_REMOVE: begin
            if (stat_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NOT_FOUND;
              state_d          = S_DONE;
            end else begin
              state_d = S_SRCH;
            end
          end
          default: begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_OK;
            state_d          = S_DONE;
          end
        endcase
      end
      S_SRCH: begin
        cmd_o.rd_off = RD_NEXT;
        if (stat_i.match) begin
          if (!stat_i.anon || stat_i.vol_eq) begin
            cmd_o.erase_sum = 1'b1;
            state_d         = S_SHIFT;
          end else if (stat_i.vol_gt) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_UNDERFLOW;
            state_d          = S_DONE;
          end else begin
            cmd_o.vol_wr     = 1'b1;
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_OK;
            state_d          = S_DONE;
          end
        end else if (stat_i.last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOT_FOUND;
          state_d          = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd_o.rd_off = RD_SKIP;
        if (!stat_i.last) begin
          cmd_o.shift_wr = 1'b1;
          cmd_o.step     = 1'b1;
        end else begin
          cmd_o.dec        = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_OK;
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/plq_dp.sv =====
module plq_dp #(
  parameter int MAX_ORDERS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         in_cmd_i,
  input  logic [31:0]        in_order_id_i,
  input  logic [31:0]        in_order_volume_i,
  input  plq_pkg::plq_cmd_t  cmd_i,
  output plq_pkg::plq_stat_t stat_o,
  output logic [1:0]         out_status_o,
  output logic [6:0]         out_order_count_o,
  output logic [31:0]        out_total_volume_o
);
  import plq_pkg::*;

  localparam int AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int CW = $clog2(MAX_ORDERS + 1);
  localparam int SW = 32 + CW;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ORDERS);

  logic [31:0] id_mem  [MAX_ORDERS];
  logic [31:0] vol_mem [MAX_ORDERS];

  logic [1:0]    req_cmd_q;
  logic [31:0]   req_id_q, req_vol_q;
  logic [CW-1:0] cmp_q, cmp_d;
  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [1:0]    status_q;
  logic [31:0]   rd_id_q, rd_vol_q;

  logic [CW-1:0] rd_sum, cmp_inc;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          id_we, vol_we;
  logic [31:0]   wr_id, wr_vol;
  logic [CW+6:0] count_ext;
  logic [31:0]   sat_sum;

  assign cmp_inc = cmp_q + CW'(1);
  assign rd_sum  = cmp_q + CW'(cmd_i.rd_off);
  assign rd_addr = rd_sum[AW-1:0];

  always_comb begin
    id_we   = 1'b0;
    vol_we  = 1'b0;
    wr_addr = cmp_q[AW-1:0];
    wr_id   = rd_id_q;
    wr_vol  = rd_vol_q;
    if (cmd_i.add_wr) begin
      id_we   = 1'b1;
      vol_we  = 1'b1;
      wr_addr = count_q[AW-1:0];
      wr_id   = req_id_q;
      wr_vol  = req_vol_q;
    end else if (cmd_i.shift_wr) begin
      id_we  = 1'b1;
      vol_we = 1'b1;
    end else if (cmd_i.vol_wr) begin
      vol_we = 1'b1;
      wr_vol = rd_vol_q - req_vol_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[wr_addr] <= wr_id;
    end
    if (vol_we) begin
      vol_mem[wr_addr] <= wr_vol;
    end
    rd_id_q  <= id_mem[rd_addr];
    rd_vol_q <= vol_mem[rd_addr];
  end

  always_comb begin
    cmp_d   = cmp_q;
    count_d = count_q;
    sum_d   = sum_q;
    if (cmd_i.load) begin
      cmp_d = '0;
    end else if (cmd_i.step) begin
      cmp_d = cmp_inc;
    end
    if (cmd_i.add_wr) begin
      count_d = count_q + CW'(1);
      sum_d   = sum_q + SW'(req_vol_q);
    end else if (cmd_i.dec) begin
      count_d = count_q - CW'(1);
    end
    if (cmd_i.erase_sum) begin
      sum_d = sum_q - SW'(rd_vol_q);
    end else if (cmd_i.vol_wr) begin
      sum_d = sum_q - SW'(req_vol_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_q <= cmp_d;
    if (cmd_i.load) begin
      req_cmd_q <= in_cmd_i;
      req_id_q  <= in_order_id_i;
      req_vol_q <= in_order_volume_i;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
  end

  assign count_ext = {7'd0, count_q};
  assign sat_sum   = (|sum_q[SW-1:32]) ? 32'hFFFF_FFFF : sum_q[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_o       <= status_q;
      out_order_count_o  <= count_ext[6:0];
      out_total_volume_o <= sat_sum;
    end
  end

  assign stat_o.cmd    = req_cmd_q;
  assign stat_o.full   = (count_q >= MaxCount);
  assign stat_o.empty  = (count_q == '0);
  assign stat_o.match  = (rd_id_q == req_id_q);
  assign stat_o.last   = (cmp_inc >= count_q);
  assign stat_o.anon   = (req_id_q == 32'd0);
  assign stat_o.vol_eq = (rd_vol_q == req_vol_q);
  assign stat_o.vol_gt = (req_vol_q > rd_vol_q);

endmodule
